// ===== rtl/core/five_point_stencil_blur_unit_assert.svh =====
// assertion macros shared by the checker files of the stencil blur unit
// expects clk and arst_n in the scope that uses them
`ifndef FIVE_POINT_STENCIL_BLUR_UNIT_ASSERT_SVH
`define FIVE_POINT_STENCIL_BLUR_UNIT_ASSERT_SVH

// same-cycle implication
`define FPSB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpsb_pkg.sv =====
// shared constants and types of the five point stencil blur unit
// no dependencies
package fpsb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W  = 8;
	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

	localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam int QPTR_W = 2;
	localparam int QDEPTH = 1 << QPTR_W;
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] pix;
	} ls_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] centre;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] right;
	} ls_rd_t;

	typedef struct packed {
		logic             two;
		logic [PIX_W-1:0] pix0;
		logic [ROW_W-1:0] row0;
		logic [PIX_W-1:0] pix1;
		logic [ROW_W-1:0] row1;
		logic [COL_W-1:0] col;
		logic             done;
	} res_entry_t;

endpackage

// ===== rtl/core/fpsb_line_store.sv =====
// two line memories: row above and row two above the incoming pixel
// read on a pixel beat, rotated and written back the next cycle; uses fpsb_pkg
module fpsb_line_store import fpsb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ls_req_t req,
	output ls_rd_t  rd
);

	logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
	logic [PIX_W-1:0] older_mem [MAX_WIDTH];

	logic [PIX_W-1:0] prev_c_q, prev_r_q, older_q;
	logic             v_s1;
	logic [COL_W-1:0] addr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             fwd_c_s1, fwd_r_s1;
	logic [PIX_W-1:0] fwd_pix_s1, fwd_old_s1;
	logic [COL_W-1:0] addr_p1;

	assign addr_p1 = req.addr + 1'b1;

	always_ff @(posedge clk) begin
		if (req.valid) begin
			prev_c_q <= prev_mem[req.addr];
			prev_r_q <= prev_mem[addr_p1];
			older_q  <= older_mem[req.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prev_mem[addr_s1]  <= pix_s1;
			older_mem[addr_s1] <= rd.centre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
		end
	end

	// write-back of the item in flight collides with the new read
	always_ff @(posedge clk) begin
		if (req.valid) begin
			addr_s1    <= req.addr;
			pix_s1     <= req.pix;
			fwd_c_s1   <= v_s1 && (addr_s1 == req.addr);
			fwd_r_s1   <= v_s1 && (addr_s1 == addr_p1);
			fwd_pix_s1 <= pix_s1;
			fwd_old_s1 <= rd.centre;
		end
	end

	always_comb begin
		rd.centre = fwd_c_s1 ? fwd_pix_s1 : prev_c_q;
		rd.right  = fwd_r_s1 ? fwd_pix_s1 : prev_r_q;
		rd.top    = fwd_c_s1 ? fwd_old_s1 : older_q;
	end

endmodule

// ===== rtl/core/fpsb_res_queue.sv =====
// result queue: one entry per pixel that yields results, holding one or two result beats
// drives the result channel; uses fpsb_pkg
module fpsb_res_queue import fpsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  res_entry_t        entry,
	output logic [QCNT_W-1:0] level,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [ROW_W-1:0]  out_row,
	output logic [COL_W-1:0]  out_col,
	output logic              run_last,
	output logic              frame_done
);

	res_entry_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              sel_q;
	res_entry_t        head;
	logic              beat, pop;

	assign head         = slot_q[rd_ptr_q];
	assign result_valid = (cnt_q != '0);
	assign beat         = result_valid && result_ready;
	assign pop          = beat && (sel_q || !head.two);
	assign level        = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (beat) begin
				sel_q <= !pop;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		out_col = head.col;
		if (sel_q) begin
			pixel_out  = head.pix1;
			out_row    = head.row1;
			run_last   = 1'b1;
			frame_done = head.done;
		end else begin
			pixel_out  = head.pix0;
			out_row    = head.row0;
			run_last   = !head.two;
			frame_done = !head.two && head.done;
		end
	end

endmodule

// ===== rtl/core/five_point_stencil_blur_unit.sv =====
// five point stencil blur: pixels in raster order, filtered row r-1 out while row r comes in
// a pixel's first result beat is offered after its stage-1 registers and result-queue write
// throughput: one pixel per clock while no register write is offered, the queue has room and
// each pixel yields at most one result; on the last row two results per pixel share one port
// reset: counters zero, size 640x480, result queue empty; line memories are not cleared
// uses fpsb_pkg, fpsb_line_store, fpsb_res_queue
module five_point_stencil_blur_unit import fpsb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [PIX_W-1:0]     pixel_out,
	output logic [ROW_W-1:0]     out_row,
	output logic [COL_W-1:0]     out_col,
	output logic                 run_last,
	output logic                 frame_done
);

	function automatic logic [PIX_W-1:0] div5(input logic [PIX_W-1:0] x);
		logic [PIX_W+9:0] p;
		p = (PIX_W + 10)'(x) * (PIX_W + 10)'(205);
		return p[PIX_W+9:10];
	endfunction

	function automatic logic [WDIM_W-1:0] clamp_w(input logic [SIZE_W-1:0] v);
		if (v == '0) return WDIM_W'(1);
		if (int'(v) > MAX_WIDTH) return WDIM_W'(MAX_WIDTH);
		return WDIM_W'(v);
	endfunction

	function automatic logic [HDIM_W-1:0] clamp_h(input logic [SIZE_W-1:0] v);
		if (v == '0) return HDIM_W'(1);
		if (int'(v) > MAX_HEIGHT) return HDIM_W'(MAX_HEIGHT);
		return HDIM_W'(v);
	endfunction

	logic [WDIM_W-1:0] w_q;
	logic [HDIM_W-1:0] h_q;
	logic [ROW_W-1:0]  r_q, r_cur;
	logic [COL_W-1:0]  c_q, c_cur;
	logic              out_of_frame, col_last, row_last;
	logic              accept;

	logic              v_s1, above_s1, own_s1, border_s1, last_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [ROW_W-1:0]  r_s1;
	logic [COL_W-1:0]  c_s1;
	logic [PIX_W-1:0]  left_q;

	ls_req_t           ls_req;
	ls_rd_t            ls_rd;
	res_entry_t        entry;
	logic              push;
	logic [QCNT_W-1:0] level;
	logic [PIX_W+1:0]  sum;
	logic [PIX_W-1:0]  filt;

	assign cfg_ready   = 1'b1;
	// a register write and a pixel beat never share an edge
	assign pixel_ready = !cfg_valid
		&& (({1'b0, level} + {{QCNT_W{1'b0}}, v_s1}) < (QCNT_W + 1)'(QDEPTH));
	assign accept      = pixel_valid && pixel_ready;

	always_comb begin
		out_of_frame = (HDIM_W'(r_q) >= h_q) || (WDIM_W'(c_q) >= w_q);
		r_cur        = out_of_frame ? '0 : r_q;
		c_cur        = out_of_frame ? '0 : c_q;
		col_last     = (WDIM_W'(c_cur) + 1'b1) >= w_q;
		row_last     = (HDIM_W'(r_cur) + 1'b1) == h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WDIM_W'(W_RESET);
			h_q <= HDIM_W'(H_RESET);
			r_q <= '0;
			c_q <= '0;
		end else begin
			if (accept) begin
				if (col_last) begin
					c_q <= '0;
					r_q <= row_last ? '0 : r_cur + 1'b1;
				end else begin
					c_q <= c_cur + 1'b1;
					r_q <= r_cur;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						w_q <= clamp_w(cfg_data);
						r_q <= '0;
						c_q <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						h_q <= clamp_h(cfg_data);
						r_q <= '0;
						c_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pixel_in;
			r_s1      <= r_cur;
			c_s1      <= c_cur;
			above_s1  <= r_cur >= ROW_W'(2);
			own_s1    <= (r_cur == '0) || row_last;
			border_s1 <= (c_cur == '0) || col_last;
			last_s1   <= row_last && col_last;
		end
		if (v_s1) begin
			left_q <= ls_rd.centre;
		end
	end

	assign ls_req.valid = accept;
	assign ls_req.addr  = c_cur;
	assign ls_req.pix   = pixel_in;

	fpsb_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ls_req),
		.rd     (ls_rd)
	);

	always_comb begin
		sum = (PIX_W + 2)'(div5(ls_rd.centre)) + (PIX_W + 2)'(div5(ls_rd.top))
			+ (PIX_W + 2)'(div5(pix_s1)) + (PIX_W + 2)'(div5(left_q))
			+ (PIX_W + 2)'(div5(ls_rd.right));
		filt = border_s1 ? ls_rd.centre : sum[PIX_W-1:0];

		entry.col  = c_s1;
		entry.done = last_s1;
		entry.pix1 = pix_s1;
		entry.row1 = r_s1;
		if (above_s1) begin
			entry.two  = own_s1;
			entry.pix0 = filt;
			entry.row0 = r_s1 - 1'b1;
		end else begin
			entry.two  = 1'b0;
			entry.pix0 = pix_s1;
			entry.row0 = r_s1;
		end
		push = v_s1 && (above_s1 || own_s1);
	end

	fpsb_res_queue u_res_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.entry        (entry),
		.level        (level),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_out    (pixel_out),
		.out_row      (out_row),
		.out_col      (out_col),
		.run_last     (run_last),
		.frame_done   (frame_done)
	);

endmodule

// ===== rtl/core/fpsb_port_checker.sv =====
// port-level checks of the five point stencil blur unit, bound to the top level
// uses fpsb_pkg and five_point_stencil_blur_unit_assert.svh
`include "five_point_stencil_blur_unit_assert.svh"

module fpsb_port_checker import fpsb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_ready,
	input logic [PIX_W-1:0]     pixel_out,
	input logic [ROW_W-1:0]     out_row,
	input logic [COL_W-1:0]     out_col,
	input logic                 run_last,
	input logic                 frame_done
);

	logic                           res_stall;
	logic                           res_first;
	logic [ROW_W-1:0]               row_next;
	logic [PIX_W+ROW_W+COL_W+1:0]   res_bus;

	assign res_stall = result_valid && !result_ready;
	assign res_first = result_valid && result_ready && !run_last;
	assign row_next  = out_row + 1'b1;
	assign res_bus   = {pixel_out, out_row, out_col, run_last, frame_done};

	// a stalled result beat stays offered
	`FPSB_ASSERT_NEXT(a_res_hold, res_stall, result_valid, "result beat dropped")

	// a stalled result beat keeps its payload
	`FPSB_ASSERT_NEXT(a_res_stable, res_stall, $stable(res_bus), "stalled result changed")

	// end of frame is always the last beat of its pixel
	`FPSB_ASSERT_SAME(a_done_last, result_valid && frame_done, run_last, "done without last")

	// filtered beat is followed at once by the same column one row down
	`FPSB_ASSERT_NEXT(a_pair_col, res_first, result_valid && $stable(out_col), "pair column moved")
	`FPSB_ASSERT_NEXT(a_pair_row, res_first, out_row == $past(row_next), "pair row not next")

endmodule

bind five_point_stencil_blur_unit fpsb_port_checker u_port_checker (.*);

// ===== tb/five_point_stencil_blur_unit_test.sv =====
// self-checking testbench of five_point_stencil_blur_unit: a directed table, a tall partial frame,
// then random frames under four idle patterns, every result beat checked against the table's
// expected beat or a line-store predictor; depends on fpsb_pkg and the unit rtl
module five_point_stencil_blur_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fpsb_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HOLD_CYCLES    = 400;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int TALL_PIXELS    = 24;
	localparam int REPORT_LIMIT   = 10;
	localparam int NUM_PHASES     = 4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last_in_run;
		logic             frame_end;
	} blur_beat_t;

	typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_PIX_KNOWN} step_kind_e;

	typedef struct packed {
		step_kind_e            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [SIZE_W-1:0]     val;
		blur_beat_t            known;
	} step_t;

	localparam int NUM_STEPS = 22;
	localparam step_t DIRECTED [NUM_STEPS] = '{
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h0FF, '{8'hFF, 10'd0, 10'd0, 1'b1, 1'b0}},
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h000, '{8'h00, 10'd0, 10'd1, 1'b1, 1'b0}},
		'{STEP_CFG,       REG_IMAGE_WIDTH,  11'd0,   '0},
		'{STEP_CFG,       REG_IMAGE_HEIGHT, 11'd0,   '0},
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h0A5, '{8'hA5, 10'd0, 10'd0, 1'b1, 1'b1}},
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h05A, '{8'h5A, 10'd0, 10'd0, 1'b1, 1'b1}},
		'{STEP_CFG,       REG_IMAGE_WIDTH,  11'd3,   '0},
		'{STEP_CFG,       REG_IMAGE_HEIGHT, 11'd3,   '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h000, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h001, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h0FF, '0},
		'{STEP_PIX,       REG_IMAGE_WIDTH,  11'h000, '0},
		'{STEP_CFG,       REG_IMAGE_WIDTH,  11'd2047, '0},
		'{STEP_CFG,       REG_IMAGE_HEIGHT, 11'd1,   '0},
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h080, '{8'h80, 10'd0, 10'd0, 1'b1, 1'b0}},
		'{STEP_CFG,       REG_UNUSED,       11'd7,   '0},
		'{STEP_PIX_KNOWN, REG_IMAGE_WIDTH,  11'h07F, '{8'h7F, 10'd0, 10'd1, 1'b1, 1'b0}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;
	logic                 pixel_valid;
	logic                 pixel_ready;
	logic [PIX_W-1:0]     pixel_in;
	logic                 result_valid;
	logic                 result_ready;
	logic [PIX_W-1:0]     pixel_out;
	logic [ROW_W-1:0]     out_row;
	logic [COL_W-1:0]     out_col;
	logic                 run_last;
	logic                 frame_done;

	logic [PIX_W-1:0]  prev_line [MAX_WIDTH];
	logic [PIX_W-1:0]  older_line [MAX_WIDTH];
	int unsigned       row_pos;
	int unsigned       col_pos;
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	blur_beat_t        blurred_due [$];

	int idle_pct;
	int stall_pct;
	int hold_asked;
	int hold_taken;
	int hold_left;
	int fail_count;
	int pixels_sent;
	int beats_seen;
	int reg_writes;
	int cycle_count;

	five_point_stencil_blur_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_out    (pixel_out),
		.out_row      (out_row),
		.out_col      (out_col),
		.run_last     (run_last),
		.frame_done   (frame_done)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned mx);
		if (v == '0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic void cfg_apply(input logic [CFG_IDX_W-1:0] idx,
			input logic [SIZE_W-1:0] val);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = val;
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = val;
		end else begin
			return;
		end
		row_pos = 0;
		col_pos = 0;
	endfunction

	function automatic int blur_predict(input logic [PIX_W-1:0] pix, output blur_beat_t first,
			output blur_beat_t second);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned val;
		int          n;
		blur_beat_t  b [2];
		b[0] = '0;
		b[1] = '0;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		n = 0;
		if (r >= h || c >= w) begin
			r = 0;
			c = 0;
		end
		if (r >= 2) begin
			if (c == 0 || c + 1 >= w) begin
				val = prev_line[c];
			end else begin
				val = 32'(prev_line[c]) / 5 + 32'(older_line[c]) / 5 + 32'(pix) / 5
					+ 32'(older_line[c-1]) / 5 + 32'(prev_line[c+1]) / 5;
			end
			b[n] = '{PIX_W'(val), ROW_W'(r - 1), COL_W'(c), 1'b0, 1'b0};
			n++;
		end
		if (r == 0 || r + 1 == h) begin
			b[n] = '{pix, ROW_W'(r), COL_W'(c), 1'b0, 1'b0};
			n++;
		end
		if (n > 0) begin
			b[n-1].last_in_run = 1'b1;
			if (r + 1 == h && c + 1 == w) b[n-1].frame_end = 1'b1;
		end
		older_line[c] = prev_line[c];
		prev_line[c] = pix;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		first = b[0];
		second = b[1];
		return n;
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic drain();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (blurred_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_apply(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
			input blur_beat_t known);
		blur_beat_t b0;
		blur_beat_t b1;
		int         n;
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_in <= pix;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		n = blur_predict(pix, b0, b1);
		if (typed) begin
			blurred_due.push_back(known);
		end else begin
			if (n > 0) blurred_due.push_back(b0);
			if (n > 1) blurred_due.push_back(b1);
		end
		pixels_sent++;
	endtask

	// output side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		blur_beat_t got;
		blur_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			got = '{pixel_out, out_row, out_col, run_last, frame_done};
			beats_seen++;
			if (blurred_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result beat: pix %0d row %0d col %0d last %0b done %0b",
						got.pix, got.row, got.col, got.last_in_run, got.frame_end);
			end else begin
				want = blurred_due.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("mismatch: want pix %0d row %0d col %0d last %0b done %0b",
							want.pix, want.row, want.col, want.last_in_run, want.frame_end);
						$display("          got  pix %0d row %0d col %0d last %0b done %0b",
							got.pix, got.row, got.col, got.last_in_run, got.frame_end);
					end
				end
			end
		end
	end

	always @(posedge clk) cycle_count++;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d beats still due", cycle_count,
			blurred_due.size());
		$display("[five_point_stencil_blur_unit] ERROR");
		$finish;
	end

	initial begin
		int w;
		int h;
		int n;
		int phase_items;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel_in = '0;
		result_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_asked = 0;
		hold_taken = 0;
		hold_left = 0;
		fail_count = 0;
		pixels_sent = 0;
		beats_seen = 0;
		reg_writes = 0;
		cycle_count = 0;
		width_reg = SIZE_W'(W_RESET);
		height_reg = SIZE_W'(H_RESET);
		row_pos = 0;
		col_pos = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			prev_line[i] = '0;
			older_line[i] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_STEPS; i++) begin
			case (DIRECTED[i].kind)
				STEP_CFG: write_reg(DIRECTED[i].idx, DIRECTED[i].val);
				STEP_PIX: send_pixel(DIRECTED[i].val[PIX_W-1:0], 1'b0, '0);
				default: send_pixel(DIRECTED[i].val[PIX_W-1:0], 1'b1, DIRECTED[i].known);
			endcase
		end

		// head of a one-column frame of the tallest height
		write_reg(REG_IMAGE_WIDTH, SIZE_W'(0));
		write_reg(REG_IMAGE_HEIGHT, SIZE_W'(2047));
		repeat (TALL_PIXELS) send_pixel(random_pixel(), 1'b0, '0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 10);
				case ($urandom_range(0, 9))
					0: w = 0;
					1: h = 0;
					default: ;
				endcase
				if (phase == 0 && phase_items == 0) begin
					w = $urandom_range(8, 16);
					h = $urandom_range(4, 8);
				end
				write_reg(REG_IMAGE_WIDTH, SIZE_W'(w));
				write_reg(REG_IMAGE_HEIGHT, SIZE_W'(h));
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_UNUSED, SIZE_W'($urandom_range(0, 2047)));
				n = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
				n = n * $urandom_range(1, 2) + (($urandom_range(0, 3) == 0) ?
					$urandom_range(1, n) : 0);
				if (n > ITEMS_PER_PHASE - phase_items) n = ITEMS_PER_PHASE - phase_items;
				if (phase == 0 && phase_items == 0) hold_asked++;
				repeat (n) send_pixel(random_pixel(), 1'b0, '0);
				phase_items += n;
			end
		end

		drain();
		$display("sent %0d pixel beats, checked %0d result beats, %0d register writes, %0d cycles",
			pixels_sent, beats_seen, reg_writes, cycle_count);
		$display("covered directed corners, the top of a 1024-row frame, random frames %s",
			"under four idle patterns with one long output hold-off");
		if (fail_count == 0) begin
			$display("[five_point_stencil_blur_unit] OK");
		end else begin
			$display("%0d failures", fail_count);
			$display("[five_point_stencil_blur_unit] ERROR");
		end
		$finish;
	end

endmodule
